// ===== hw/rtl/rlp_pkg.sv =====
// Package for the request line parser: item and result types, phase and
// status codes, keyword tables and byte class helpers.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rlp_pkg;

	localparam int MAX_WORD_LEN = 12;
	localparam int NUM_KW = 5;
	localparam int KW_SLOTS = 16;

	localparam logic [3:0] MAX_WORD_LEN_W = 4'(MAX_WORD_LEN);

	typedef enum logic [5:0] {
		PH_LEAD  = 6'b000001,
		PH_ID    = 6'b000010,
		PH_GAP   = 6'b000100,
		PH_WORD  = 6'b001000,
		PH_TRAIL = 6'b010000,
		PH_DONE  = 6'b100000
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BAD_ID  = 3'd1,
		ST_MISSING = 3'd2,
		ST_EXTRA   = 3'd3,
		ST_UNKNOWN = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       line_end;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] request_id;
		logic [2:0]  command;
	} result_t;

	// Keyword text, zero padded to 16 bytes; byte i sits at [(15-i)*8 +: 8].
	localparam logic [KW_SLOTS*8-1:0] KW_HELLO   = {"hello", {11{8'h00}}};
	localparam logic [KW_SLOTS*8-1:0] KW_VERSION = {"version", {9{8'h00}}};
	localparam logic [KW_SLOTS*8-1:0] KW_CAPS    = {"capabilities", {4{8'h00}}};
	localparam logic [KW_SLOTS*8-1:0] KW_PING    = {"ping", {12{8'h00}}};
	localparam logic [KW_SLOTS*8-1:0] KW_QUIT    = {"quit-client", {5{8'h00}}};

	localparam logic [NUM_KW-1:0][KW_SLOTS*8-1:0] KW_TEXT =
		{KW_QUIT, KW_PING, KW_CAPS, KW_VERSION, KW_HELLO};
	localparam logic [NUM_KW-1:0][3:0] KW_LEN = {4'd11, 4'd4, 4'd12, 4'd7, 4'd5};

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic is_term(input logic [7:0] c);
		return (c == CH_NUL) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rlp_in_stage.sv =====
// Input register of the request line parser: holds one byte item until the
// parser takes it. Depends on rlp_pkg for the item type.
`default_nettype none
module rlp_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire rlp_pkg::item_t in_item,
	input  wire logic          advance,
	output logic               valid_s1,
	output rlp_pkg::item_t     item_s1
);

	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/rlp_parser.sv =====
// Parse state of the request line parser and the per-byte next-state logic,
// including the result of a line on its last byte. Depends on rlp_pkg.
`default_nettype none
module rlp_parser (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           take,
	input  wire rlp_pkg::item_t item,
	output rlp_pkg::result_t    result
);

	rlp_pkg::phase_t phase_q, phase_n;
	logic [31:0] acc_q, acc_n;
	logic        ovf_q, ovf_n;
	logic [3:0]  wl_q, wl_n;
	logic [rlp_pkg::NUM_KW-1:0] hits_q, hits_n;
	logic [2:0]  perr_q, perr_n;

	logic [7:0]  c;
	logic [35:0] prod;
	logic [rlp_pkg::NUM_KW-1:0] hits_word;
	logic [3:0]  wl_word;
	logic        match_cur, match_nxt;
	logic [2:0]  code_nxt;
	logic [2:0]  fin_status;

	assign c = item.char_byte;

	// acc * 10 + digit, with the top nibble showing overflow.
	assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, c[3:0]};

	// Keyword hits after one more word byte.
	always_comb begin
		hits_word = hits_q;
		wl_word = wl_q;
		if (wl_q >= rlp_pkg::MAX_WORD_LEN_W || wl_q == 4'd15) begin
			hits_word = '0;
		end else begin
			for (int k = 0; k < rlp_pkg::NUM_KW; k++) begin
				if (wl_q >= rlp_pkg::KW_LEN[k] ||
				    rlp_pkg::KW_TEXT[k][{~wl_q, 3'b000} +: 8] != c) begin
					hits_word[k] = 1'b0;
				end
			end
			wl_word = wl_q + 4'd1;
		end
	end

	always_comb begin
		match_cur = 1'b0;
		for (int k = 0; k < rlp_pkg::NUM_KW; k++) begin
			if (hits_q[k] && wl_q == rlp_pkg::KW_LEN[k] &&
			    rlp_pkg::KW_LEN[k] <= rlp_pkg::MAX_WORD_LEN_W) begin
				match_cur = 1'b1;
			end
		end
	end

	// Lowest keyword index wins.
	always_comb begin
		match_nxt = 1'b0;
		code_nxt = '0;
		for (int k = rlp_pkg::NUM_KW - 1; k >= 0; k--) begin
			if (hits_n[k] && wl_n == rlp_pkg::KW_LEN[k] &&
			    rlp_pkg::KW_LEN[k] <= rlp_pkg::MAX_WORD_LEN_W) begin
				match_nxt = 1'b1;
				code_nxt = 3'(k);
			end
		end
	end

	always_comb begin
		phase_n = phase_q;
		acc_n = acc_q;
		ovf_n = ovf_q;
		wl_n = wl_q;
		hits_n = hits_q;
		perr_n = perr_q;
		if (phase_q != rlp_pkg::PH_DONE) begin
			if (rlp_pkg::is_term(c)) begin
				phase_n = rlp_pkg::PH_DONE;
				case (phase_q)
					rlp_pkg::PH_LEAD:  perr_n = rlp_pkg::ST_BAD_ID;
					rlp_pkg::PH_ID:    perr_n = ovf_q ? rlp_pkg::ST_BAD_ID
					                                  : rlp_pkg::ST_MISSING;
					rlp_pkg::PH_GAP:   perr_n = rlp_pkg::ST_MISSING;
					rlp_pkg::PH_WORD,
					rlp_pkg::PH_TRAIL: perr_n = match_cur ? rlp_pkg::ST_OK
					                                      : rlp_pkg::ST_UNKNOWN;
					default:           perr_n = perr_q;
				endcase
			end else begin
				case (phase_q)
					rlp_pkg::PH_LEAD: begin
						if (rlp_pkg::is_digit(c)) begin
							acc_n = {28'd0, c[3:0]};
							phase_n = rlp_pkg::PH_ID;
						end else if (!rlp_pkg::is_blank(c)) begin
							perr_n = rlp_pkg::ST_BAD_ID;
							phase_n = rlp_pkg::PH_DONE;
						end
					end
					rlp_pkg::PH_ID: begin
						if (rlp_pkg::is_digit(c)) begin
							acc_n = prod[31:0];
							if (prod[35:32] != 4'd0) begin
								ovf_n = 1'b1;
							end
						end else if (ovf_q) begin
							perr_n = rlp_pkg::ST_BAD_ID;
							phase_n = rlp_pkg::PH_DONE;
						end else if (rlp_pkg::is_blank(c)) begin
							phase_n = rlp_pkg::PH_GAP;
						end else begin
							perr_n = rlp_pkg::ST_MISSING;
							phase_n = rlp_pkg::PH_DONE;
						end
					end
					rlp_pkg::PH_GAP: begin
						if (!rlp_pkg::is_blank(c)) begin
							phase_n = rlp_pkg::PH_WORD;
							hits_n = hits_word;
							wl_n = wl_word;
						end
					end
					rlp_pkg::PH_WORD: begin
						if (rlp_pkg::is_blank(c)) begin
							phase_n = rlp_pkg::PH_TRAIL;
						end else begin
							hits_n = hits_word;
							wl_n = wl_word;
						end
					end
					rlp_pkg::PH_TRAIL: begin
						if (!rlp_pkg::is_blank(c)) begin
							perr_n = rlp_pkg::ST_EXTRA;
							phase_n = rlp_pkg::PH_DONE;
						end
					end
					default: begin
						phase_n = phase_q;
					end
				endcase
			end
		end
	end

	// The line ends after this byte: close whatever phase it left behind.
	always_comb begin
		case (phase_n)
			rlp_pkg::PH_LEAD:  fin_status = rlp_pkg::ST_BAD_ID;
			rlp_pkg::PH_ID:    fin_status = ovf_n ? rlp_pkg::ST_BAD_ID : rlp_pkg::ST_MISSING;
			rlp_pkg::PH_GAP:   fin_status = rlp_pkg::ST_MISSING;
			rlp_pkg::PH_WORD,
			rlp_pkg::PH_TRAIL: fin_status = match_nxt ? rlp_pkg::ST_OK : rlp_pkg::ST_UNKNOWN;
			default:           fin_status = perr_n;
		endcase
	end

	always_comb begin
		result.status = fin_status;
		result.request_id = (fin_status == rlp_pkg::ST_BAD_ID) ? 32'd0 : acc_n;
		result.command = (fin_status == rlp_pkg::ST_OK) ? code_nxt : 3'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rlp_pkg::PH_LEAD;
			acc_q <= '0;
			ovf_q <= 1'b0;
			wl_q <= '0;
			hits_q <= '1;
			perr_q <= rlp_pkg::ST_OK;
		end else if (take) begin
			if (item.line_end) begin
				phase_q <= rlp_pkg::PH_LEAD;
				acc_q <= '0;
				ovf_q <= 1'b0;
				wl_q <= '0;
				hits_q <= '1;
				perr_q <= rlp_pkg::ST_OK;
			end else begin
				phase_q <= phase_n;
				acc_q <= acc_n;
				ovf_q <= ovf_n;
				wl_q <= wl_n;
				hits_q <= hits_n;
				perr_q <= perr_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/rlp_out_stage.sv =====
// Result register of the request line parser: holds one line result until
// the downstream side takes it. Depends on rlp_pkg for the result type.
`default_nettype none
module rlp_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire rlp_pkg::result_t load_result,
	output logic                  free,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output rlp_pkg::result_t      out_result
);

	logic valid_q;
	rlp_pkg::result_t result_q;

	assign free = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= load_result;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/request_line_parser.sv =====
// Request line parser, one byte item per cycle while in_stall is low: the input
// register, the parse state, and the result register. Uses rlp_pkg,
// rlp_in_stage, rlp_parser and rlp_out_stage.
//
// The block takes one character per item and keeps up with one item every
// clock cycle unless a line_end item waits; the per-byte work is a phase
// update plus a multiply-by-ten accumulate, done between the input register
// and the parse state. The result of a line is computed from its line_end
// item in the input register and loaded into the result register, and only
// that item of a line gives one. Bytes that carry no result keep flowing
// while a result waits to be taken; a line_end item waits in the input register
// only while the previous result is still held by a stall on the output.
`default_nettype none
module request_line_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_byte,
	input  wire logic        line_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [31:0]      request_id,
	output logic [2:0]       command
);

	rlp_pkg::item_t   in_item, item_s1;
	rlp_pkg::result_t line_result, out_result;
	logic valid_s1, advance, out_free, load;

	assign in_item.char_byte = char_byte;
	assign in_item.line_end = line_end;

	// An item without a result never waits for the output side.
	assign advance = valid_s1 && (!item_s1.line_end || out_free);
	assign load = advance && item_s1.line_end;

	rlp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rlp_parser u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (advance),
		.item   (item_s1),
		.result (line_result)
	);

	rlp_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.load_result (line_result),
		.free        (out_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_result  (out_result)
	);

	assign status = out_result.status;
	assign request_id = out_result.request_id;
	assign command = out_result.command;

endmodule
`default_nettype wire
